/* sv/lcs_pkg.sv */
// Shared types and constants for the linear congruence solver.
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int FIELD_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int DEF_WIDTH = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_SOLVED      = 2'd0,
        ST_NO_SOLUTION = 2'd1,
        ST_ZERO_MOD    = 2'd2
    } status_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic qbit_valid;
        logic qbit;
    } div_stat_t;

endpackage

/* sv/linear_congruence_solver.sv */
// Top level of the linear congruence solver: sequencer around a shared divider.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | input     | in_valid / in_stall  | operand_a, operand_b, modulus
//   out     | output    | out_valid / out_stall| status, solution, common_divisor
//
// An item with a zero modulus goes straight to the output stage. Otherwise each Euclid
// quotient step is one division in the shared divider, followed by the four final
// divisions and the multiply; there are at most 46 Euclid steps for 32-bit operands.
// The input is stalled while an item is in work; a finished transaction waits in the
// output register while the next transaction is accepted. Reset clears only control
// state.
`timescale 1ns / 1ps

module linear_congruence_solver #(
    parameter int WIDTH = lcs_pkg::DEF_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lcs_pkg::FIELD_W-1:0]   operand_a,
    input  logic [lcs_pkg::FIELD_W-1:0]   operand_b,
    input  logic [lcs_pkg::FIELD_W-1:0]   modulus,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lcs_pkg::STATUS_W-1:0]  status,
    output logic [lcs_pkg::FIELD_W-1:0]   solution,
    output logic [lcs_pkg::FIELD_W-1:0]   common_divisor
);

    localparam int FW = lcs_pkg::FIELD_W;
    localparam int TW = WIDTH + 2;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_EUC  = 10'b0000000010,
        S_EDIV = 10'b0000000100,
        S_BDIV = 10'b0000001000,
        S_NDIV = 10'b0000010000,
        S_TDIV = 10'b0000100000,
        S_MUL  = 10'b0001000000,
        S_PDIV = 10'b0010000000,
        S_OUT  = 10'b0100000000,
        S_SPARE = 10'b1000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;

    logic [WIDTH-1:0]       b_reg, b_next;
    logic [WIDTH-1:0]       n_reg, n_next;
    logic [WIDTH-1:0]       r0_reg, r0_next;
    logic [WIDTH-1:0]       r1_reg, r1_next;
    logic signed [TW-1:0]   t0_reg, t0_next;
    logic signed [TW-1:0]   t1_reg, t1_next;
    logic signed [TW-1:0]   acc_reg, acc_next;
    logic [WIDTH-1:0]       bg_reg, bg_next;
    logic [WIDTH-1:0]       m_reg, m_next;
    logic [WIDTH-1:0]       tm_reg, tm_next;
    lcs_pkg::status_t       res_status_reg, res_status_next;
    logic [WIDTH-1:0]       res_sol_reg, res_sol_next;
    logic [WIDTH-1:0]       res_g_reg, res_g_next;
    lcs_pkg::status_t       out_status_reg, out_status_next;
    logic [WIDTH-1:0]       out_sol_reg, out_sol_next;
    logic [WIDTH-1:0]       out_g_reg, out_g_next;

    logic                   div_start;
    logic                   div_long;
    logic [2*WIDTH-1:0]     div_dividend;
    logic [WIDTH-1:0]       div_divisor;
    lcs_pkg::div_stat_t     div_stat;
    logic [WIDTH-1:0]       div_quo;
    logic [WIDTH-1:0]       div_rem;

    logic                   in_fire;
    logic                   out_fire;
    logic [WIDTH-1:0]       a_in;
    logic [WIDTH-1:0]       n_in;
    logic signed [TW-1:0]   t0_neg;
    logic [WIDTH-1:0]       t0_abs;
    logic [2*WIDTH-1:0]     prod;

    lcs_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .long_mode (div_long),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign a_in     = operand_a[WIDTH-1:0];
    assign n_in     = modulus[WIDTH-1:0];
    assign t0_neg   = -t0_reg;
    assign t0_abs   = t0_reg[TW-1] ? t0_neg[WIDTH-1:0] : t0_reg[WIDTH-1:0];
    assign prod     = (2 * WIDTH)'(tm_reg) * (2 * WIDTH)'(bg_reg);

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        b_next          = b_reg;
        n_next          = n_reg;
        r0_next         = r0_reg;
        r1_next         = r1_reg;
        t0_next         = t0_reg;
        t1_next         = t1_reg;
        acc_next        = acc_reg;
        bg_next         = bg_reg;
        m_next          = m_reg;
        tm_next         = tm_reg;
        res_status_next = res_status_reg;
        res_sol_next    = res_sol_reg;
        res_g_next      = res_g_reg;
        out_status_next = out_status_reg;
        out_sol_next    = out_sol_reg;
        out_g_next      = out_g_reg;
        div_start       = 1'b0;
        div_long        = 1'b0;
        div_dividend    = {r0_reg, {WIDTH{1'b0}}};
        div_divisor     = r1_reg;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    b_next  = operand_b[WIDTH-1:0];
                    n_next  = n_in;
                    r0_next = n_in;
                    r1_next = a_in;
                    t0_next = '0;
                    t1_next = TW'(1);
                    if (n_in == '0)
                    begin
                        res_status_next = lcs_pkg::ST_ZERO_MOD;
                        res_sol_next    = '0;
                        res_g_next      = '0;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_EUC;
                    end
                end
            end
            S_EUC:
            begin
                if (r1_reg == '0)
                begin
                    res_g_next   = r0_reg;
                    div_start    = 1'b1;
                    div_dividend = {b_reg, {WIDTH{1'b0}}};
                    div_divisor  = r0_reg;
                    state_next   = S_BDIV;
                end
                else
                begin
                    acc_next   = '0;
                    div_start  = 1'b1;
                    state_next = S_EDIV;
                end
            end
            S_EDIV:
            begin
                if (div_stat.qbit_valid)
                begin
                    acc_next = (acc_reg <<< 1) + (div_stat.qbit ? t1_reg : TW'(0));
                end
                if (div_stat.done)
                begin
                    r0_next    = r1_reg;
                    r1_next    = div_rem;
                    t0_next    = t1_reg;
                    t1_next    = t0_reg - acc_reg;
                    state_next = S_EUC;
                end
            end
            S_BDIV:
            begin
                if (div_stat.done)
                begin
                    if (div_rem != '0)
                    begin
                        res_status_next = lcs_pkg::ST_NO_SOLUTION;
                        res_sol_next    = '0;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        bg_next      = div_quo;
                        div_start    = 1'b1;
                        div_dividend = {n_reg, {WIDTH{1'b0}}};
                        div_divisor  = res_g_reg;
                        state_next   = S_NDIV;
                    end
                end
            end
            S_NDIV:
            begin
                if (div_stat.done)
                begin
                    m_next       = div_quo;
                    div_start    = 1'b1;
                    div_dividend = {t0_abs, {WIDTH{1'b0}}};
                    div_divisor  = div_quo;
                    state_next   = S_TDIV;
                end
            end
            S_TDIV:
            begin
                if (div_stat.done)
                begin
                    tm_next    = (t0_reg[TW-1] && div_rem != '0) ? m_reg - div_rem : div_rem;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                div_start    = 1'b1;
                div_long     = 1'b1;
                div_dividend = prod;
                div_divisor  = m_reg;
                state_next   = S_PDIV;
            end
            S_PDIV:
            begin
                if (div_stat.done)
                begin
                    res_status_next = lcs_pkg::ST_SOLVED;
                    res_sol_next    = div_rem;
                    state_next      = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_sol_next    = res_sol_reg;
                    out_g_next      = res_g_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg          <= b_next;
        n_reg          <= n_next;
        r0_reg         <= r0_next;
        r1_reg         <= r1_next;
        t0_reg         <= t0_next;
        t1_reg         <= t1_next;
        acc_reg        <= acc_next;
        bg_reg         <= bg_next;
        m_reg          <= m_next;
        tm_reg         <= tm_next;
        res_status_reg <= res_status_next;
        res_sol_reg    <= res_sol_next;
        res_g_reg      <= res_g_next;
        out_status_reg <= out_status_next;
        out_sol_reg    <= out_sol_next;
        out_g_reg      <= out_g_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign solution       = FW'(out_sol_reg);
    assign common_divisor = FW'(out_g_reg);

`ifndef SYNTHESIS
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_stat.busy && !div_stat.done)
        else $error("divider active while the sequencer is idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_EDIV || state_reg == S_BDIV ||
                          state_reg == S_NDIV || state_reg == S_TDIV || state_reg == S_PDIV)
        else $error("divider finished outside a wait state");

    a_zero_mod_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == lcs_pkg::ST_ZERO_MOD |-> solution == '0 && common_divisor == '0)
        else $error("zero modulus transaction carries nonzero fields");
`endif

endmodule

/* sv/lcs_div.sv */
// Shared restoring divider, one quotient bit per cycle, short or long dividend.
`timescale 1ns / 1ps

module lcs_div #(
    parameter int WIDTH = lcs_pkg::DEF_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   long_mode,
    input  logic [2*WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]       divisor,
    output lcs_pkg::div_stat_t     stat,
    output logic [WIDTH-1:0]       quotient,
    output logic [WIDTH-1:0]       remainder
);

    localparam int CW = $clog2(2 * WIDTH + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [2*WIDTH-1:0] dvd_reg;
    logic [WIDTH-1:0]  dvs_reg;
    logic [WIDTH-1:0]  rem_reg;
    logic [WIDTH-1:0]  quo_reg;

    logic [WIDTH:0]    trial;
    logic [WIDTH:0]    diff;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[2*WIDTH-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= long_mode ? CW'(2 * WIDTH) : CW'(WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[2*WIDTH-2:0], 1'b0};
            rem_reg <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_reg <= {quo_reg[WIDTH-2:0], ge};
        end
    end

    assign stat.busy       = busy_reg;
    assign stat.done       = done_reg;
    assign stat.qbit_valid = busy_reg;
    assign stat.qbit       = ge;
    assign quotient        = quo_reg;
    assign remainder       = rem_reg;

endmodule

/* dv/linear_congruence_solver_tb.sv */
// Self-checking testbench for the linear congruence solver with randomized handshakes.
`timescale 1ns / 1ps

module linear_congruence_solver_tb;

    localparam int WIDTH         = lcs_pkg::DEF_WIDTH;
    localparam int FW            = lcs_pkg::FIELD_W;
    localparam int IDLE_PCT      = 12;
    localparam int RANDOM_ITEMS  = 1230;
    localparam int HOLD_OFF_LEN  = 3000;
    localparam int HOLD_OFF_AT   = 150;
    localparam int QUIET_FROM    = 500;
    localparam int QUIET_TO      = 750;
    localparam int DRAIN_CYCLES  = 2000;
    localparam int STALL_LIMIT   = 20000;

    typedef struct packed {
        logic [FW-1:0] a;
        logic [FW-1:0] b;
        logic [FW-1:0] n;
    } congruence_t;

    typedef struct packed {
        lcs_pkg::status_t status;
        logic [FW-1:0]    solution;
        logic [FW-1:0]    common_divisor;
    } residue_result_t;

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [FW-1:0]                operand_a = '0;
    logic [FW-1:0]                operand_b = '0;
    logic [FW-1:0]                modulus = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [lcs_pkg::STATUS_W-1:0] status;
    logic [FW-1:0]                solution;
    logic [FW-1:0]                common_divisor;

    congruence_t     pending_items[$];
    residue_result_t expected_results[$];
    congruence_t     next_item;
    residue_result_t oldest_expected;
    int              total_items;
    int              sent_count = 0;
    int              received_count = 0;
    int              solved_count = 0;
    int              unsolvable_count = 0;
    int              zero_mod_count = 0;
    int              error_count = 0;
    int              hold_left = 0;
    logic            hold_done = 1'b0;
    int              quiet_cycles = 0;
    logic            quiet;

    assign quiet = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);

    linear_congruence_solver #(
        .WIDTH(WIDTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .modulus        (modulus),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .solution       (solution),
        .common_divisor (common_divisor)
    );

    function automatic void queue_item(congruence_t item);
        pending_items = {pending_items, item};
    endfunction

    function automatic void queue_expected(residue_result_t res);
        expected_results = {expected_results, res};
    endfunction

    function automatic logic [63:0] gcd_of(logic [63:0] p, logic [63:0] q);
        logic [63:0] r;
        while (q != 0)
        begin
            r = p % q;
            p = q;
            q = r;
        end
        return p;
    endfunction

    // Bezout coefficient of a is carried as a residue modulo m to stay unsigned.
    function automatic logic [63:0] modular_inverse(logic [63:0] a, logic [63:0] m);
        logic [63:0] r0, r1, r2, t0, t1, t2, q, qt;
        r0 = m;
        r1 = a % m;
        t0 = '0;
        t1 = 64'd1;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            qt = ((q % m) * t1) % m;
            t2 = (t0 + m - qt) % m;
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        return t0 % m;
    endfunction

    function automatic residue_result_t solve_congruence(congruence_t item);
        logic [63:0]     mask, a, b, n, g, m, inv, x;
        residue_result_t res;
        mask = (64'd1 << WIDTH) - 64'd1;
        a = {32'd0, item.a} & mask;
        b = {32'd0, item.b} & mask;
        n = {32'd0, item.n} & mask;
        res.status         = lcs_pkg::ST_SOLVED;
        res.solution       = '0;
        res.common_divisor = '0;
        if (n == 0)
        begin
            res.status = lcs_pkg::ST_ZERO_MOD;
        end
        else
        begin
            g = gcd_of(a, n);
            res.common_divisor = g[FW-1:0];
            if (b % g != 0)
            begin
                res.status = lcs_pkg::ST_NO_SOLUTION;
            end
            else
            begin
                m = n / g;
                if (m > 1)
                begin
                    inv = modular_inverse((a / g) % m, m);
                    x   = (((b / g) % m) * inv) % m;
                    res.solution = x[FW-1:0];
                end
            end
        end
        return res;
    endfunction

    function automatic congruence_t random_congruence();
        congruence_t item;
        logic [63:0] g, lim, scaled;
        item.a = $urandom;
        item.b = $urandom;
        item.n = $urandom;
        case ($urandom_range(0, 9))
            0: item.n = '0;
            1:
            begin
                item.a = $urandom_range(0, 3);
                item.n = $urandom_range(0, 1) ? $urandom_range(1, 1000) : $urandom;
                item.b = $urandom_range(0, 1) ? item.n * $urandom_range(0, 7) : $urandom;
            end
            2, 3, 4: ;
            5, 6, 7:
            begin
                g      = {32'd0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'h00FF_FFFF)
                                                             : $urandom_range(1, 1000)};
                lim    = 64'hFFFF_FFFF / g;
                scaled = g * {32'd0, $urandom_range(0, lim[31:0])};
                item.a = scaled[FW-1:0];
                scaled = g * {32'd0, $urandom_range(1, lim[31:0])};
                item.n = scaled[FW-1:0];
                scaled = g * {32'd0, $urandom_range(0, lim[31:0])};
                item.b = ($urandom_range(0, 4) == 0) ? $urandom : scaled[FW-1:0];
            end
            8:
            begin
                item.a = $urandom_range(0, 255);
                item.b = $urandom_range(0, 255);
                item.n = $urandom_range(0, 255);
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: item.n = 1;
                    1: item.a = item.n;
                    default: item.n = 32'd1 << $urandom_range(0, 31);
                endcase
            end
        endcase
        return item;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                queue_expected(solve_congruence({operand_a, operand_b, modulus}));
                sent_count <= sent_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_item = pending_items.pop_front();
                    in_valid  <= 1'b1;
                    operand_a <= next_item.a;
                    operand_b <= next_item.b;
                    modulus   <= next_item.n;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off lets the solver fill up and stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && sent_count >= HOLD_OFF_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left != 1);
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            received_count++;
            if (expected_results.size() == 0)
            begin
                $error("Unexpected transaction: status %0d, solution %0d, common_divisor %0d",
                       status, solution, common_divisor);
                error_count++;
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                case (oldest_expected.status)
                    lcs_pkg::ST_SOLVED:      solved_count++;
                    lcs_pkg::ST_NO_SOLUTION: unsolvable_count++;
                    default:                 zero_mod_count++;
                endcase
                if (status !== oldest_expected.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           oldest_expected.status, status);
                    error_count++;
                end
                if (solution !== oldest_expected.solution)
                begin
                    $error("solution mismatch: expected %0d, actual %0d",
                           oldest_expected.solution, solution);
                    error_count++;
                end
                if (common_divisor !== oldest_expected.common_divisor)
                begin
                    $error("common_divisor mismatch: expected %0d, actual %0d",
                           oldest_expected.common_divisor, common_divisor);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("No transaction for %0d cycles.", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        queue_item('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000});
        queue_item('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        queue_item('{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF});
        queue_item('{32'h0000_0000, 32'h0000_0005, 32'h0000_0007});
        queue_item('{32'h0000_0000, 32'h0000_000E, 32'h0000_0007});
        queue_item('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        queue_item('{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        queue_item('{32'h0000_0003, 32'h0000_0001, 32'hFFFF_FFFF});
        queue_item('{32'h0000_0006, 32'h0000_0004, 32'h0000_000A});
        queue_item('{32'h0000_0002, 32'h0000_0003, 32'h0000_0004});
        queue_item('{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE});
        queue_item('{32'd1836311903, 32'hFFFF_FFFF, 32'd2971215073});
        queue_item('{32'd2971215073, 32'h1234_5678, 32'd1836311903});
        queue_item('{32'h0000_0064, 32'h0000_0007, 32'h0000_0009});
        queue_item('{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0001});
        queue_item('{32'h8000_0000, 32'h0000_0000, 32'h8000_0000});
        queue_item('{32'h0000_3039, 32'hDEAD_BEEF, 32'h0001_0000});
        queue_item('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE});
        queue_item('{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF});
        queue_item('{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFB});
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            queue_item(random_congruence());
        end
        total_items = pending_items.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (sent_count == total_items);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d transactions: %0d solved, %0d without solution,",
                 received_count, total_items, solved_count, unsolvable_count);
        $display("%0d zero modulus, with a %0d-cycle output hold-off and a stretch without idling.",
                 zero_mod_count, HOLD_OFF_LEN);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
